@@ hw/rtl/hsrd_pkg.sv @@
// Shared types and constants of the scanline run-length decoder.
package hsrd_pkg;

  localparam int unsigned LINE_WIDTH_W = 13;
  localparam int unsigned COLUMN_W     = 12;
  localparam int unsigned RUN_W        = 7;
  localparam int unsigned CHANNEL_W    = 2;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned HEADER_W     = 3;

  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 13'd4096;
  localparam logic [HEADER_W-1:0]     HEADER_BYTES     = 3'd4;
  localparam logic [CHANNEL_W-1:0]    CHAN_EXPONENT    = 2'd3;

  // Register indexes of the configuration port.
  localparam logic REG_LINE_WIDTH = 1'b0;

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [COLUMN_W-1:0]  start_column;
    logic [RUN_W-1:0]     run_length;
    logic [BYTE_W-1:0]    byte_value;
    logic                 line_done;
    logic                 overrun;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ hw/rtl/hsrd_intf.sv @@
// Request channel interfaces: encoded bytes in, run descriptors out.
interface hsrd_in_if;
  import hsrd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface hsrd_out_if;
  import hsrd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CHANNEL_W-1:0] channel;
  logic [COLUMN_W-1:0]  start_column;
  logic [RUN_W-1:0]     run_length;
  logic [BYTE_W-1:0]    byte_value;
  logic                 line_done;
  logic                 overrun;
  modport source (output valid, output channel, output start_column, output run_length,
                  output byte_value, output line_done, output overrun, input ready);
  modport sink (input valid, input channel, input start_column, input run_length,
                input byte_value, input line_done, input overrun, output ready);
endinterface

@@ hw/rtl/hsrd_front.sv @@
// Front end: byte classification and scanline bookkeeping.
module hsrd_front #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [hsrd_pkg::BYTE_W-1:0]    data_byte,
  input  logic [hsrd_pkg::LINE_WIDTH_W-1:0] line_width,
  input  logic                           restart,
  output hsrd_pkg::push_t                push
);
  import hsrd_pkg::*;

  typedef enum logic [1:0] {
    PH_CODE,
    PH_LITERAL,
    PH_RUN
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [HEADER_W-1:0]     header_r, header_nxt;
  logic [CHANNEL_W-1:0]    chan_r, chan_nxt;
  logic [LINE_WIDTH_W-1:0] col_r, col_nxt;
  logic [RUN_W-1:0]        cnt_r, cnt_nxt;
  logic                    clamp_r, clamp_nxt;

  logic [LINE_WIDTH_W-1:0] eff_w;
  logic [LINE_WIDTH_W-1:0] rem;
  logic [RUN_W-1:0]        code_cnt;
  logic                    code_clamp;
  logic                    emit;
  logic [RUN_W-1:0]        emit_len;
  logic                    emit_ovr;
  logic [LINE_WIDTH_W:0]   col_sum;
  logic                    line_end;
  logic                    done;

  always_comb begin
    eff_w = line_width;
    if (line_width == '0) begin
      eff_w = LINE_WIDTH_W'(1);
    end else if (16'(line_width) > 16'(MAX_WIDTH)) begin
      eff_w = LINE_WIDTH_W'(MAX_WIDTH);
    end
  end

  always_comb begin
    rem = (col_r < eff_w) ? (eff_w - col_r) : '0;
    if (rem == '0) begin
      rem = LINE_WIDTH_W'(1);
    end
    code_cnt   = data_byte[RUN_W-1:0];
    code_clamp = LINE_WIDTH_W'(code_cnt) > rem;
  end

  always_comb begin
    header_nxt = header_r;
    phase_nxt  = phase_r;
    chan_nxt   = chan_r;
    col_nxt    = col_r;
    cnt_nxt    = cnt_r;
    clamp_nxt  = clamp_r;
    emit       = 1'b0;
    emit_len   = RUN_W'(1);
    emit_ovr   = clamp_r;
    done       = 1'b0;
    col_sum    = '0;
    line_end   = 1'b0;

    if (header_r != '0) begin
      header_nxt = header_r - HEADER_W'(1);
    end else begin
      case (phase_r)
        PH_LITERAL: begin
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - RUN_W'(1);
          end
          if (cnt_nxt == '0) begin
            phase_nxt = PH_CODE;
            clamp_nxt = 1'b0;
          end
          emit = 1'b1;
        end
        PH_RUN: begin
          phase_nxt = PH_CODE;
          cnt_nxt   = '0;
          clamp_nxt = 1'b0;
          emit      = cnt_r != '0;
          emit_len  = cnt_r;
        end
        default: begin
          if (data_byte[BYTE_W-1] || code_cnt != '0) begin
            clamp_nxt = code_clamp;
            cnt_nxt   = code_clamp ? rem[RUN_W-1:0] : code_cnt;
            phase_nxt = data_byte[BYTE_W-1] ? PH_RUN : PH_LITERAL;
          end
        end
      endcase

      if (emit) begin
        col_sum  = (LINE_WIDTH_W+1)'(col_r) + (LINE_WIDTH_W+1)'(emit_len);
        line_end = col_sum >= (LINE_WIDTH_W+1)'(eff_w);
        if (line_end) begin
          col_nxt   = '0;
          phase_nxt = PH_CODE;
          cnt_nxt   = '0;
          clamp_nxt = 1'b0;
          if (chan_r == CHAN_EXPONENT) begin
            done       = 1'b1;
            chan_nxt   = '0;
            header_nxt = HEADER_BYTES;
          end else begin
            chan_nxt = chan_r + CHANNEL_W'(1);
          end
        end else begin
          col_nxt = col_sum[LINE_WIDTH_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      phase_r  <= PH_CODE;
      header_r <= HEADER_BYTES;
      chan_r   <= '0;
      col_r    <= '0;
      cnt_r    <= '0;
      clamp_r  <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      header_r <= header_nxt;
      chan_r   <= chan_nxt;
      col_r    <= col_nxt;
      cnt_r    <= cnt_nxt;
      clamp_r  <= clamp_nxt;
    end
  end

  always_comb begin
    push.valid             = accept && emit;
    push.desc.channel      = chan_r;
    push.desc.start_column = col_r[COLUMN_W-1:0];
    push.desc.run_length   = emit_len;
    push.desc.byte_value   = data_byte;
    push.desc.line_done    = done;
    push.desc.overrun      = emit_ovr;
  end

endmodule

@@ hw/rtl/hsrd_queue.sv @@
// Back end: descriptor queue that feeds the result channel.
module hsrd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hsrd_pkg::push_t     push,
  input  logic                pop,
  output hsrd_pkg::desc_t     head,
  output hsrd_pkg::q_status_t status
);
  import hsrd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  desc_t              mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign status.full  = count_r == CNT_W'(DEPTH);
  assign status.empty = count_r == '0;
  assign do_push      = push.valid && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.desc;
    end
  end

endmodule

@@ hw/rtl/hdr_scanline_rle_decoder_top.sv @@
// Top level of the scanline run-length decoder with its configuration port.
// A descriptor is written into the descriptor queue as its byte is taken.
// Throughput: one byte per cycle while the queue is not full; the front end updates per byte.
// The four-entry descriptor queue lets the byte side run on while results wait.
// Reset (rst_n low, synchronous) empties the queue, sets line_width to 4096 and
// restarts decoding at the header of a new scanline.
module hdr_scanline_rle_decoder_top #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  hsrd_in_if.sink           in_chan,
  hsrd_out_if.source        out_chan,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import hsrd_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 4;

  logic [LINE_WIDTH_W-1:0] line_width_r;
  logic                    cfg_write;
  logic                    in_accept;
  push_t                   push;
  desc_t                   head;
  q_status_t               q_status;

  // The register is written in the access phase of an APB request. Any write of
  // line_width also throws the decoder back to the start of a scanline.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_LINE_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RESET;
    end else if (cfg_write) begin
      line_width_r <= cfg_pwdata[LINE_WIDTH_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_LINE_WIDTH) begin
      cfg_prdata = 32'(line_width_r);
    end
  end

  // Bytes are taken whenever the queue has room for the descriptor they might cause.
  assign in_chan.ready = !q_status.full;
  assign in_accept     = in_chan.valid && in_chan.ready;

  hsrd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .data_byte  (in_chan.data_byte),
    .line_width (line_width_r),
    .restart    (cfg_write),
    .push       (push)
  );

  hsrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (out_chan.ready),
    .head   (head),
    .status (q_status)
  );

  // The head of the queue is presented directly on the result channel.
  assign out_chan.valid        = !q_status.empty;
  assign out_chan.channel      = head.channel;
  assign out_chan.start_column = head.start_column;
  assign out_chan.run_length   = head.run_length;
  assign out_chan.byte_value   = head.byte_value;
  assign out_chan.line_done    = head.line_done;
  assign out_chan.overrun      = head.overrun;

  // A stalled input side means the queue is full, so a result must be on offer.
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_chan.valid)
    else $error("input stalled with no result pending");

  // Only the exponent channel can finish a scanline.
  a_done_on_exponent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.line_done) |-> (out_chan.channel == CHAN_EXPONENT))
    else $error("line_done on a channel other than exponent");

  // Zero-length codes never produce a descriptor.
  a_nonzero_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.run_length != '0))
    else $error("descriptor with zero run length");

  // A descriptor pushed by an accepted byte means a result is on offer in the next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |=> out_chan.valid)
    else $error("pushed descriptor not visible");

endmodule
